### design/pcc_pkg.sv
// Shared types and constants for the clamped PID controller.
// Holds the register map, loop modes, config and term bundles.
// No dependencies.
`default_nettype none

package pcc_pkg;

  localparam int unsigned DataW     = 16;
  localparam int unsigned LimW      = 15;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned ErrW      = 17;
  localparam int unsigned DiffW     = 18;
  localparam int unsigned PProdW    = 33;
  localparam int unsigned DProdW    = 34;
  localparam int unsigned IntegW    = 25;
  localparam int unsigned IntegSumW = 34;
  localparam int unsigned SumW      = 36;
  localparam int unsigned FracW     = 8;

  typedef enum logic [CfgAddrW-1:0] {
    REG_TARGET   = 3'd0,
    REG_PGAIN    = 3'd1,
    REG_IGAIN    = 3'd2,
    REG_DGAIN    = 3'd3,
    REG_ILIMIT   = 3'd4,
    REG_OLIMIT   = 3'd5,
    REG_MODE     = 3'd6,
    REG_RESERVED = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_PID = 2'd0,
    MODE_PD  = 2'd1,
    MODE_PI  = 2'd2,
    MODE_P   = 2'd3
  } loop_mode_t;

  localparam logic [LimW-1:0] OutputLimitReset = 15'h7FFF;

  typedef struct packed {
    logic signed [DataW-1:0] target_value;
    logic [DataW-1:0]        prop_gain;
    logic [DataW-1:0]        integ_gain;
    logic [DataW-1:0]        deriv_gain;
    logic [LimW-1:0]         integ_limit;
    logic [LimW-1:0]         output_limit;
    loop_mode_t              loop_mode;
  } pcc_cfg_t;

  typedef struct packed {
    logic signed [PProdW-1:0] p_term;
    logic signed [DProdW-1:0] d_term;
    logic signed [PProdW-1:0] i_prod;
  } pcc_terms_t;

endpackage

`default_nettype wire

### design/pcc_term.sv
// Term stage: error, error change and the three gain products, registered.
// Holds the previous error. Uses pcc_pkg.
`default_nettype none

module pcc_term (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pcc_pkg::pcc_cfg_t              cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [pcc_pkg::DataW-1:0] meas,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output pcc_pkg::pcc_terms_t                 terms
);

  logic signed [pcc_pkg::ErrW-1:0]   prev_error;
  logic signed [pcc_pkg::ErrW-1:0]   err;
  logic signed [pcc_pkg::DiffW-1:0]  diff;
  logic signed [pcc_pkg::PProdW-1:0] p_prod;
  logic signed [pcc_pkg::DProdW-1:0] d_full;
  logic signed [pcc_pkg::DProdW-1:0] d_prod;
  logic signed [pcc_pkg::PProdW-1:0] i_prod;
  logic                              use_d;
  logic                              adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign err  = {cfg.target_value[pcc_pkg::DataW-1], cfg.target_value}
              - {meas[pcc_pkg::DataW-1], meas};
  assign diff = {err[pcc_pkg::ErrW-1], err} - {prev_error[pcc_pkg::ErrW-1], prev_error};

  assign use_d = (cfg.loop_mode == pcc_pkg::MODE_PID) || (cfg.loop_mode == pcc_pkg::MODE_PD);

  assign p_prod = $signed({1'b0, cfg.prop_gain}) * err;
  assign i_prod = $signed({1'b0, cfg.integ_gain}) * err;
  assign d_full = $signed({1'b0, cfg.deriv_gain}) * diff;
  assign d_prod = use_d ? d_full : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_error <= '0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        prev_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      terms.p_term <= p_prod;
      terms.d_term <= d_prod;
      terms.i_prod <= i_prod;
    end
  end

endmodule

`default_nettype wire

### design/pcc_sum.sv
// Sum stage: integral update with clamp, term sum, shift and output clamp.
// Holds the integral and the result register. Uses pcc_pkg.
`default_nettype none

module pcc_sum (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pcc_pkg::pcc_cfg_t          cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire pcc_pkg::pcc_terms_t        terms,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [pcc_pkg::DataW-1:0]       drive
);

  logic signed [pcc_pkg::IntegW-1:0]    integ_acc;
  logic signed [pcc_pkg::IntegW-1:0]    integ_next;
  logic signed [pcc_pkg::IntegSumW-1:0] acc_sum;
  logic signed [pcc_pkg::IntegSumW-1:0] ilim;
  logic signed [pcc_pkg::IntegSumW-1:0] acc_clamped;
  logic signed [pcc_pkg::SumW-1:0]      sum;
  logic signed [pcc_pkg::SumW-1:0]      shifted;
  logic signed [pcc_pkg::SumW-1:0]      olim;
  logic signed [pcc_pkg::SumW-1:0]      drive_wide;
  logic                                 use_i;
  logic                                 adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign use_i = (cfg.loop_mode == pcc_pkg::MODE_PID) || (cfg.loop_mode == pcc_pkg::MODE_PI);

  assign acc_sum = pcc_pkg::IntegSumW'(integ_acc) + pcc_pkg::IntegSumW'(terms.i_prod);
  assign ilim    = $signed({11'b0, cfg.integ_limit, pcc_pkg::FracW'(0)});

  always_comb begin
    priority if (acc_sum > ilim) begin
      acc_clamped = ilim;
    end else if (acc_sum < -ilim) begin
      acc_clamped = -ilim;
    end else begin
      acc_clamped = acc_sum;
    end
  end

  assign integ_next = use_i ? acc_clamped[pcc_pkg::IntegW-1:0] : '0;

  assign sum = pcc_pkg::SumW'(terms.p_term) + pcc_pkg::SumW'(terms.d_term)
             + pcc_pkg::SumW'(integ_next);
  assign shifted = sum >>> pcc_pkg::FracW;
  assign olim    = $signed({21'b0, cfg.output_limit});

  always_comb begin
    priority if (shifted > olim) begin
      drive_wide = olim;
    end else if (shifted < -olim) begin
      drive_wide = -olim;
    end else begin
      drive_wide = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      integ_acc <= '0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        integ_acc <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      drive <= drive_wide[pcc_pkg::DataW-1:0];
    end
  end

endmodule

`default_nettype wire

### design/pid_controller_clamped_unit.sv
// Path: an accepted input beat passes the input, term and result registers,
// in that order, before its drive beat is offered.
// Throughput: one beat per cycle while the output is not stalled; the integral
// register closes its update loop within the sum stage.
// Reset clears all valid flags, the previous error and the integral, and
// loads register defaults (output limit 32767, others zero).
// Top level of the clamped PID controller; uses pcc_pkg, pcc_term, pcc_sum.
`default_nettype none

module pid_controller_clamped_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [pcc_pkg::DataW-1:0]     s_tdata,   // [15:0] measured_value
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [pcc_pkg::DataW-1:0]          m_tdata,   // [15:0] drive_value
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pcc_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [pcc_pkg::DataW-1:0]     cfg_data
);

  pcc_pkg::pcc_cfg_t             cfg;
  pcc_pkg::pcc_terms_t           terms;
  logic                          in_valid;
  logic signed [pcc_pkg::DataW-1:0] meas;
  logic                          term_ready;
  logic                          term_valid;
  logic                          sum_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_value <= '0;
      cfg.prop_gain    <= '0;
      cfg.integ_gain   <= '0;
      cfg.deriv_gain   <= '0;
      cfg.integ_limit  <= '0;
      cfg.output_limit <= pcc_pkg::OutputLimitReset;
      cfg.loop_mode    <= pcc_pkg::MODE_PID;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcc_pkg::reg_index_t'(cfg_addr))
        pcc_pkg::REG_TARGET: cfg.target_value <= $signed(cfg_data);
        pcc_pkg::REG_PGAIN:  cfg.prop_gain    <= cfg_data;
        pcc_pkg::REG_IGAIN:  cfg.integ_gain   <= cfg_data;
        pcc_pkg::REG_DGAIN:  cfg.deriv_gain   <= cfg_data;
        pcc_pkg::REG_ILIMIT: cfg.integ_limit  <= cfg_data[pcc_pkg::LimW-1:0];
        pcc_pkg::REG_OLIMIT: cfg.output_limit <= cfg_data[pcc_pkg::LimW-1:0];
        pcc_pkg::REG_MODE:   cfg.loop_mode    <= pcc_pkg::loop_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  assign s_tready = !in_valid || term_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      meas <= $signed(s_tdata);
    end
  end

  pcc_term u_term (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (term_ready),
    .meas      (meas),
    .out_valid (term_valid),
    .out_ready (sum_ready),
    .terms     (terms)
  );

  pcc_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (term_valid),
    .in_ready  (sum_ready),
    .terms     (terms),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .drive     (m_tdata)
  );

endmodule

`default_nettype wire

### design/pcc_checker.sv
// Port-level checks for the clamped PID controller, bound to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module pcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("drive beat valid right after reset");

  a_no_min_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata != 16'h8000)
    else $error("drive beat outside symmetric clamp");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled while output register is empty");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled drive beat changed");

endmodule

bind pid_controller_clamped_unit pcc_checker u_pcc_checker (.*);

`default_nettype wire

### sim/tb_pid_controller_clamped_unit.sv
// Self-checking testbench for pid_controller_clamped_unit: random stream stimulus,
// a cycle-free model of the controller predicts every drive beat.
// Depends on pcc_pkg and the unit under test only.
`default_nettype none

module tb_pid_controller_clamped_unit;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned HoldAtBeat    = 600;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned PhaseItems    = 160;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [pcc_pkg::DataW-1:0]    s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [pcc_pkg::DataW-1:0]    m_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [pcc_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [pcc_pkg::DataW-1:0]    cfg_data = '0;

  pid_controller_clamped_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  // controller settings as last written
  logic signed [pcc_pkg::DataW-1:0] target_reg = '0;
  logic [pcc_pkg::DataW-1:0]        pgain_reg  = '0;
  logic [pcc_pkg::DataW-1:0]        igain_reg  = '0;
  logic [pcc_pkg::DataW-1:0]        dgain_reg  = '0;
  logic [pcc_pkg::LimW-1:0]         ilim_reg   = '0;
  logic [pcc_pkg::LimW-1:0]         olim_reg   = pcc_pkg::OutputLimitReset;
  pcc_pkg::loop_mode_t              mode_reg   = pcc_pkg::MODE_PID;

  // controller state
  logic signed [pcc_pkg::ErrW-1:0]   last_err  = '0;
  logic signed [pcc_pkg::IntegW-1:0] integ_val = '0;

  logic [pcc_pkg::DataW-1:0] sample_q[$];
  logic [pcc_pkg::DataW-1:0] drive_q[$];

  int unsigned queued_total  = 0;
  int unsigned rx_total      = 0;
  int unsigned fail_count    = 0;
  int unsigned setting_count = 0;
  int unsigned src_idle_pct  = 15;
  int unsigned sink_idle_pct = 15;
  int unsigned quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [pcc_pkg::DataW-1:0] predict_drive(
      logic [pcc_pkg::DataW-1:0] sample);
    longint err;
    longint p_part;
    longint d_part;
    longint acc;
    longint lim;
    longint total;
    longint drive;
    err = longint'(target_reg) - longint'($signed(sample));
    p_part = longint'(pgain_reg) * err;
    d_part = 0;
    if (mode_reg == pcc_pkg::MODE_PID || mode_reg == pcc_pkg::MODE_PD) begin
      d_part = longint'(dgain_reg) * (err - longint'(last_err));
    end
    if (mode_reg == pcc_pkg::MODE_PID || mode_reg == pcc_pkg::MODE_PI) begin
      acc = longint'(integ_val) + longint'(igain_reg) * err;
      lim = longint'(ilim_reg) * 256;
      if (acc > lim) begin
        acc = lim;
      end else if (acc < -lim) begin
        acc = -lim;
      end
      integ_val = acc[pcc_pkg::IntegW-1:0];
    end else begin
      integ_val = '0;
    end
    last_err = err[pcc_pkg::ErrW-1:0];
    total = p_part + d_part + longint'(integ_val);
    drive = total >>> pcc_pkg::FracW;
    if (drive > longint'(olim_reg)) begin
      drive = longint'(olim_reg);
    end else if (drive < -longint'(olim_reg)) begin
      drive = -longint'(olim_reg);
    end
    return drive[pcc_pkg::DataW-1:0];
  endfunction

  // sender: hold the beat until accepted, then advance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        drive_q.push_back(predict_drive(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each drive beat, stall at random and once for a long stretch
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin : drive_check
    logic [pcc_pkg::DataW-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        rx_total++;
        if (drive_q.size() == 0) begin
          fail_count++;
          if (fail_count < 20) begin
            $error("drive_value: no beat expected, got %0d", $signed(m_tdata));
          end
        end else begin
          want = drive_q.pop_front();
          if (m_tdata !== want) begin
            fail_count++;
            if (fail_count < 20) begin
              $error("drive_value mismatch: expected %0d, got %0d",
                     $signed(want), $signed(m_tdata));
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && rx_total >= HoldAtBeat) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_pid_controller_clamped_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(pcc_pkg::reg_index_t idx, logic [pcc_pkg::DataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pcc_pkg::REG_TARGET: target_reg = val;
      pcc_pkg::REG_PGAIN:  pgain_reg  = val;
      pcc_pkg::REG_IGAIN:  igain_reg  = val;
      pcc_pkg::REG_DGAIN:  dgain_reg  = val;
      pcc_pkg::REG_ILIMIT: ilim_reg   = val[pcc_pkg::LimW-1:0];
      pcc_pkg::REG_OLIMIT: olim_reg   = val[pcc_pkg::LimW-1:0];
      pcc_pkg::REG_MODE:   mode_reg   = pcc_pkg::loop_mode_t'(val[1:0]);
      default: ;
    endcase
  endtask

  task automatic queue_sample(logic [pcc_pkg::DataW-1:0] v);
    sample_q.push_back(v);
    queued_total++;
  endtask

  task automatic settle();
    while (rx_total < queued_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(pcc_pkg::loop_mode_t m);
    logic [pcc_pkg::DataW-1:0] v;
    v = pcc_pkg::DataW'($urandom);
    v[1:0] = m;
    write_reg(pcc_pkg::REG_MODE, v);
  endtask

  function automatic logic [pcc_pkg::DataW-1:0] pick_gain();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 3) return pcc_pkg::DataW'($urandom);
    return pcc_pkg::DataW'($urandom_range(1023));
  endfunction

  function automatic logic [pcc_pkg::DataW-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return pcc_pkg::DataW'($urandom);
    return pcc_pkg::DataW'($urandom_range(4000));
  endfunction

  function automatic logic [pcc_pkg::DataW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3, 4, 5: return pcc_pkg::DataW'(int'(target_reg) + int'($urandom_range(512)) - 256);
      default: return pcc_pkg::DataW'($urandom);
    endcase
  endfunction

  initial begin
    logic [pcc_pkg::DataW-1:0] v;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // defaults: zero gains give zero drive
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    settle();

    write_reg(pcc_pkg::REG_TARGET, 16'h0000);
    write_reg(pcc_pkg::REG_PGAIN, 16'h0100);
    write_reg(pcc_pkg::REG_IGAIN, 16'h0040);
    write_reg(pcc_pkg::REG_DGAIN, 16'h0080);
    write_reg(pcc_pkg::REG_ILIMIT, 16'h0200);
    write_reg(pcc_pkg::REG_OLIMIT, 16'h7FFF);
    write_reg(pcc_pkg::REG_MODE, pcc_pkg::MODE_PID);
    setting_count++;
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h0000);
    queue_sample(16'hFFFF);
    queue_sample(16'h0001);
    queue_sample(16'h5555);
    queue_sample(16'hAAAA);
    settle();

    write_reg(pcc_pkg::REG_MODE, pcc_pkg::MODE_PD);
    queue_sample(16'h1234);
    queue_sample(16'hEDCC);
    settle();
    write_reg(pcc_pkg::REG_MODE, pcc_pkg::MODE_PI);
    queue_sample(16'h4000);
    queue_sample(16'hC000);
    settle();
    write_reg(pcc_pkg::REG_MODE, pcc_pkg::MODE_P);
    queue_sample(16'h0100);
    queue_sample(16'hFF00);
    settle();
    setting_count += 3;

    // zero limits, full gains, extreme setpoint
    write_reg(pcc_pkg::REG_TARGET, 16'h8000);
    write_reg(pcc_pkg::REG_PGAIN, 16'hFFFF);
    write_reg(pcc_pkg::REG_IGAIN, 16'hFFFF);
    write_reg(pcc_pkg::REG_DGAIN, 16'hFFFF);
    write_reg(pcc_pkg::REG_ILIMIT, 16'h0000);
    write_reg(pcc_pkg::REG_OLIMIT, 16'h0000);
    write_reg(pcc_pkg::REG_MODE, pcc_pkg::MODE_PID);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    settle();
    // upper bits beyond the register width drop
    write_reg(pcc_pkg::REG_OLIMIT, 16'hFFFF);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    settle();
    write_reg(pcc_pkg::REG_ILIMIT, 16'hFFFF);
    write_reg(pcc_pkg::REG_TARGET, 16'h7FFF);
    write_mode(pcc_pkg::MODE_PID);
    write_reg(pcc_pkg::REG_RESERVED, 16'hFFFF);
    queue_sample(16'h8000);
    queue_sample(16'h0000);
    settle();
    setting_count += 3;

    for (int ph = 0; ph < PhaseCount; ph++) begin
      src_idle_pct  = (ph == 2) ? 0 : 15;
      sink_idle_pct = (ph == 2) ? 0 : 15;
      case ($urandom_range(3))
        0: v = pcc_pkg::DataW'($urandom);
        1: v = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        default: v = pcc_pkg::DataW'(int'($urandom_range(4000)) - 2000);
      endcase
      write_reg(pcc_pkg::REG_TARGET, v);
      write_reg(pcc_pkg::REG_PGAIN, pick_gain());
      write_reg(pcc_pkg::REG_IGAIN, pick_gain());
      write_reg(pcc_pkg::REG_DGAIN, pick_gain());
      write_reg(pcc_pkg::REG_ILIMIT, pick_limit());
      write_reg(pcc_pkg::REG_OLIMIT, pick_limit());
      write_mode(pcc_pkg::loop_mode_t'(ph % 4));
      if ($urandom_range(3) == 0) begin
        write_reg(pcc_pkg::REG_RESERVED, pcc_pkg::DataW'($urandom));
      end
      setting_count++;
      for (int k = 0; k < PhaseItems; k++) begin
        queue_sample(pick_sample());
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (drive_q.size() != 0) begin
      fail_count++;
      $error("drive_value: %0d expected beats never arrived", drive_q.size());
    end
    $display("Covered %0d samples over %0d controller settings, all four loop modes,",
             queued_total, setting_count);
    $display("zero and full limits, extreme gains and setpoints, and a %0d-cycle output stall.",
             HoldCycles);
    if (fail_count == 0) begin
      $display("tb_pid_controller_clamped_unit: PASS");
    end else begin
      $display("tb_pid_controller_clamped_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/pcc_pkg.sv
design/pcc_term.sv
design/pcc_sum.sv
design/pid_controller_clamped_unit.sv
design/pcc_checker.sv
sim/tb_pid_controller_clamped_unit.sv
